// ===== rtl/iill_pkg.sv =====
// Package for the indirect index level lookup: sizes, codes and the job record.
// Depends on nothing; every rtl file imports it.
package iill_pkg;

  localparam int MAX_ENTRIES = 512;
  localparam int MAX_LEVEL   = 8;

  localparam int ADDR_W  = $clog2(MAX_ENTRIES);
  localparam int ID_W    = 64;
  localparam int REF_W   = 64;
  localparam int CNT_W   = 10;
  localparam int LVL_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  // Clamp limits that fit the register widths
  localparam int CNT_CAP = (MAX_ENTRIES < 1023) ? MAX_ENTRIES : 1023;
  localparam int LVL_CAP = (MAX_LEVEL < 15) ? MAX_LEVEL : 15;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEVEL = 2'd1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  typedef struct packed {
    logic             op;
    logic [ID_W-1:0]  id;
    logic             must;
    logic [REF_W-1:0] new_ref;
    logic [ID_W-1:0]  power;
    logic             huge;
    logic [CNT_W-1:0] count;
  } iill_job_t;

endpackage

// ===== rtl/indirect_index_level_lookup.sv =====
// Top level of the indirect index level lookup: front end, job queue, back end.
// Depends on iill_pkg, iill_front, iill_queue and iill_back.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------
//   config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//   request  | start / busy              | operation_i, object_id_i, must_exist_i,
//            |                           | new_reference_i
//   result   | done_o (one-cycle strobe) | reference_o, next_object_id_o, status_o
//
// An item passes the power loop, the push into the queue, the pop, the divider,
// the check state and, for a read, the read state.
// A power past 64 bits skips the divider. The back end takes a new item only
// when done with the last; the front computes the next power while it divides.
// After reset the back end clears the store, with busy high.
// Config is taken anytime. Results cannot be stalled: done_o pulses once per item.
module indirect_index_level_lookup (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [iill_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [iill_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation_i,
  input  logic [iill_pkg::ID_W-1:0]      object_id_i,
  input  logic                           must_exist_i,
  input  logic [iill_pkg::REF_W-1:0]     new_reference_i,
  output logic                           done_o,
  output logic [iill_pkg::REF_W-1:0]     reference_o,
  output logic [iill_pkg::ID_W-1:0]      next_object_id_o,
  output logic [1:0]                     status_o
);
  import iill_pkg::*;

  iill_job_t push_job;
  iill_job_t pop_job;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;
  logic      clearing;

  // Intake, config and divisor power
  iill_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .object_id_i     (object_id_i),
    .must_exist_i    (must_exist_i),
    .new_reference_i (new_reference_i),
    .clearing_i      (clearing),
    .q_full_i        (q_full),
    .push_o          (push),
    .job_o           (push_job)
  );

  // Hold jobs so front and back stall independently
  iill_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .job_o   (pop_job)
  );

  // Divide, check bounds, access the store, report
  iill_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (q_empty),
    .job_i            (pop_job),
    .pop_o            (pop),
    .clearing_o       (clearing),
    .done_o           (done_o),
    .reference_o      (reference_o),
    .next_object_id_o (next_object_id_o),
    .status_o         (status_o)
  );

endmodule

// ===== rtl/iill_front.sv =====
// Front end: configuration registers, item intake and the divisor power loop.
// Depends on iill_pkg; feeds iill_queue.
module iill_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [iill_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [iill_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation_i,
  input  logic [iill_pkg::ID_W-1:0]      object_id_i,
  input  logic                           must_exist_i,
  input  logic [iill_pkg::REF_W-1:0]     new_reference_i,
  input  logic                           clearing_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output iill_pkg::iill_job_t            job_o
);
  import iill_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_POW, F_PUSH} fstate_e;

  fstate_e          state_q;
  logic [CNT_W-1:0] entry_count_q;
  logic [LVL_W-1:0] level_cfg_q;
  logic [LVL_W-1:0] steps_q;
  iill_job_t        job_q;
  logic [CNT_W-1:0] count_eff;
  logic [LVL_W-1:0] level_eff;
  logic [ID_W+CNT_W-1:0] prod;

  always_comb begin
    count_eff = entry_count_q;
    if (entry_count_q < CNT_W'(2)) begin
      count_eff = CNT_W'(2);
    end else if (32'(entry_count_q) > CNT_CAP) begin
      count_eff = CNT_W'(CNT_CAP);
    end
    level_eff = level_cfg_q;
    if (level_cfg_q == '0) begin
      level_eff = LVL_W'(1);
    end else if (32'(level_cfg_q) > LVL_CAP) begin
      level_eff = LVL_W'(LVL_CAP);
    end
  end

  assign prod        = (ID_W+CNT_W)'(job_q.power) * (ID_W+CNT_W)'(job_q.count);
  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != F_IDLE) || clearing_i;
  assign push_o      = (state_q == F_PUSH) && !q_full_i;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= F_IDLE;
      entry_count_q <= CNT_W'(512);
      level_cfg_q   <= LVL_W'(1);
      steps_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_ENTRY_COUNT) begin
          entry_count_q <= cfg_data_i;
        end else if (cfg_index_i == REG_BLOCK_LEVEL) begin
          level_cfg_q <= cfg_data_i[LVL_W-1:0];
        end
      end
      unique case (state_q)
        F_IDLE: begin
          if (start && !busy) begin
            steps_q <= level_eff - LVL_W'(1);
            state_q <= F_POW;
          end
        end
        F_POW: begin
          if (steps_q == '0 || job_q.huge) begin
            state_q <= F_PUSH;
          end else begin
            steps_q <= steps_q - LVL_W'(1);
          end
        end
        F_PUSH: begin
          if (!q_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // Job payload: load on intake, multiply the power up once per step
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && start && !busy) begin
      job_q.op      <= operation_i;
      job_q.id      <= object_id_i;
      job_q.must    <= must_exist_i;
      job_q.new_ref <= new_reference_i;
      job_q.count   <= count_eff;
      job_q.power   <= ID_W'(count_eff);
      job_q.huge    <= 1'b0;
    end else if (state_q == F_POW && steps_q != '0 && !job_q.huge) begin
      if (prod[ID_W+CNT_W-1:ID_W] != '0) begin
        job_q.huge <= 1'b1;
      end else begin
        job_q.power <= prod[ID_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/iill_queue.sv =====
// Two-entry job queue between front and back end.
// Depends on iill_pkg.
module iill_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  iill_pkg::iill_job_t job_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output iill_pkg::iill_job_t job_o
);
  import iill_pkg::*;

  iill_job_t  mem_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule

// ===== rtl/iill_back.sv =====
// Back end: clearing pass, bit-serial divider, bounds check and reference store.
// Depends on iill_pkg; pops jobs from iill_queue.
module iill_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  iill_pkg::iill_job_t        job_i,
  output logic                       pop_o,
  output logic                       clearing_o,
  output logic                       done_o,
  output logic [iill_pkg::REF_W-1:0] reference_o,
  output logic [iill_pkg::ID_W-1:0]  next_object_id_o,
  output logic [1:0]                 status_o
);
  import iill_pkg::*;

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_DIV, B_CHECK, B_READ} bstate_e;

  bstate_e           state_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic [6:0]        bit_q;
  logic              op_q;
  logic              must_q;
  logic [REF_W-1:0]  new_ref_q;
  logic [ID_W-1:0]   power_q;
  logic [CNT_W-1:0]  count_q;
  logic [ID_W-1:0]   quo_q;
  logic [ID_W-1:0]   rem_q;
  logic [ID_W:0]     rem_sh;
  logic              fits;
  logic              oob;
  logic [REF_W-1:0]  store_q [MAX_ENTRIES];
  logic [REF_W-1:0]  rdata_q;
  logic              we;
  logic              re;
  logic [ADDR_W-1:0] addr;
  logic [REF_W-1:0]  wdata;

  assign rem_sh     = {rem_q, quo_q[ID_W-1]};
  assign fits       = rem_sh >= {1'b0, power_q};
  assign oob        = quo_q >= ID_W'(count_q);
  assign pop_o      = (state_q == B_IDLE) && !empty_i;
  assign clearing_o = (state_q == B_CLEAR);

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    addr  = quo_q[ADDR_W-1:0];
    wdata = new_ref_q;
    if (state_q == B_CLEAR) begin
      we    = 1'b1;
      addr  = clr_addr_q;
      wdata = '0;
    end else if (state_q == B_CHECK && !oob) begin
      we = (op_q == OP_WRITE);
      re = (op_q == OP_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[addr] <= wdata;
    end
    if (re) begin
      rdata_q <= store_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_addr_q  <= '0;
      bit_q       <= '0;
      done_o      <= 1'b0;
      reference_o <= '0;
      status_o    <= ST_OK;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        B_CLEAR: begin
          clr_addr_q <= clr_addr_q + ADDR_W'(1);
          if (clr_addr_q == ADDR_W'(MAX_ENTRIES - 1)) begin
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!empty_i) begin
            bit_q   <= '0;
            state_q <= job_i.huge ? B_CHECK : B_DIV;
          end
        end
        B_DIV: begin
          bit_q <= bit_q + 7'd1;
          if (bit_q == 7'(ID_W - 1)) begin
            state_q <= B_CHECK;
          end
        end
        B_CHECK: begin
          if (oob || op_q == OP_WRITE) begin
            done_o      <= 1'b1;
            reference_o <= '0;
            status_o    <= oob ? ((op_q == OP_WRITE || must_q) ? ST_ERROR : ST_MISSING)
                               : ST_OK;
            state_q     <= B_IDLE;
          end else begin
            state_q <= B_READ;
          end
        end
        B_READ: begin
          done_o      <= 1'b1;
          reference_o <= rdata_q;
          status_o    <= ST_OK;
          state_q     <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // Datapath: restoring division, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && !empty_i) begin
      op_q      <= job_i.op;
      must_q    <= job_i.must;
      new_ref_q <= job_i.new_ref;
      power_q   <= job_i.power;
      count_q   <= job_i.count;
      rem_q     <= '0;
      if (job_i.huge) begin
        quo_q            <= '0;
        next_object_id_o <= job_i.id;
      end else begin
        quo_q <= job_i.id - ID_W'(1);
      end
    end else if (state_q == B_DIV) begin
      quo_q <= {quo_q[ID_W-2:0], fits};
      rem_q <= fits ? ID_W'(rem_sh - {1'b0, power_q}) : rem_sh[ID_W-1:0];
      if (bit_q == 7'(ID_W - 1)) begin
        next_object_id_o <= (fits ? ID_W'(rem_sh - {1'b0, power_q}) : rem_sh[ID_W-1:0])
                            + ID_W'(1);
      end
    end
  end

endmodule
